// File: hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Fan speed controller package
// Beat types, register and mode codes, working widths and the percent to
// duty mapping shared by the controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

    localparam int TEMP_FRAC_BITS = 4;
    localparam int DUTY_BITS      = 10;

    localparam int PCT_W   = 7;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int KICK_W  = 16;
    localparam int THR_W   = 6;
    localparam int CW      = TEMP_FRAC_BITS + 14;
    localparam int NUM_W   = TEMP_FRAC_BITS + 13;
    localparam int DEN_W   = TEMP_FRAC_BITS + 6;
    localparam int QUO_W   = 8;
    localparam int QCNT_W  = $clog2(QUO_W);

    localparam logic [IDX_W-1:0] REG_FAN_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_THR   = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_THR  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_DUTY  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KICK      = 3'd4;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_OFF  = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;
    localparam logic [1:0] MODE_FULL = 2'd3;

    localparam logic [PCT_W-1:0] PCT_OFF       = 7'd0;
    localparam logic [PCT_W-1:0] PCT_RAMP_BASE = 7'd20;
    localparam logic [PCT_W-1:0] PCT_HALF      = 7'd50;
    localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL = DUTY_BITS'((1 << DUTY_BITS) - 1);

    localparam logic [63:0] PCT_RECIP = ((64'd1 << 32) + 64'd99) / 64'd100;
    localparam logic [63:0] DUTY_MUL  = 64'((1 << DUTY_BITS) - 1) * PCT_RECIP;

    typedef struct packed {
        logic              kind;
        logic              temp_present;
        logic signed [11:0] fin_temp;
    } t_in_beat;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic [PCT_W-1:0]     level_pct;
        logic                 kicking;
    } t_out_beat;

    typedef struct packed {
        logic apply;
        logic tick;
    } t_drv_ctl;

    typedef struct packed {
        logic [THR_W-1:0]  min_duty;
        logic [KICK_W-1:0] kick_ticks;
    } t_drv_cfg;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    // Floor of pct * full scale / 100, taken as a multiply by a scaled reciprocal.
    function automatic logic [DUTY_BITS-1:0] pct_to_duty(input logic [PCT_W-1:0] pct);
        logic [63:0] prod;
        prod = 64'(pct) * DUTY_MUL;
        return prod[32 +: DUTY_BITS];
    endfunction

endpackage

`default_nettype wire

// File: hdl/fsc_div.sv
// ----------------------------------------------------------------------------
// Fan speed controller ramp divider
// Restoring divider that forms one quotient bit per cycle, most significant
// bit first, from a numerator known to be below the divisor times 2^QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  fsc_pkg::t_div_req   i_req,
    output fsc_pkg::t_div_rsp   o_rsp
);
    import fsc_pkg::*;

    logic [NUM_W-1:0]  r_rem,  n_rem;
    logic [NUM_W-1:0]  r_dsh,  n_dsh;
    logic [QUO_W-1:0]  r_quo,  n_quo;
    logic [QCNT_W-1:0] r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    always_comb begin
        n_rem  = r_rem;
        n_dsh  = r_dsh;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_dsh  = NUM_W'(i_req.den) << (QUO_W - 1);
            n_cnt  = QCNT_W'(QUO_W - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= r_dsh) begin
                n_rem = r_rem - r_dsh;
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end
            n_dsh = r_dsh >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// File: hdl/fsc_drive.sv
// ----------------------------------------------------------------------------
// Fan speed controller output drive
// Holds the decided and applied percent, runs the start kick on ticks and
// keeps the PWM duty register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsc_drive (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  fsc_pkg::t_drv_ctl             i_ctl,
    input  wire  [fsc_pkg::PCT_W-1:0]     i_pct,
    input  fsc_pkg::t_drv_cfg             i_cfg,
    output logic [fsc_pkg::PCT_W-1:0]     o_speed,
    output fsc_pkg::t_out_beat            o_next
);
    import fsc_pkg::*;

    logic [PCT_W-1:0]     r_speed,   n_speed;
    logic [PCT_W-1:0]     r_applied, n_applied;
    logic [PCT_W-1:0]     r_target,  n_target;
    logic [KICK_W-1:0]    r_left,    n_left;
    logic [DUTY_BITS-1:0] r_duty,    n_duty;
    logic [PCT_W-1:0]     w_floor;
    logic [PCT_W-1:0]     w_dsel;
    logic                 w_load;

    always_comb begin
        w_floor = i_pct;
        if (i_pct != PCT_OFF && i_pct < PCT_W'(i_cfg.min_duty)) begin
            w_floor = PCT_W'(i_cfg.min_duty);
        end
        n_speed   = r_speed;
        n_applied = r_applied;
        n_target  = r_target;
        n_left    = r_left;
        w_dsel    = r_target;
        w_load    = 1'b0;
        if (!i_ctl.tick) begin
            if (i_pct != r_speed) begin
                n_speed   = i_pct;
                n_applied = w_floor;
                w_load    = 1'b1;
                if (r_applied == PCT_OFF && w_floor != PCT_OFF && i_cfg.kick_ticks != '0) begin
                    n_target = w_floor;
                    n_left   = i_cfg.kick_ticks;
                    w_dsel   = PCT_FULL;
                end else begin
                    n_left = '0;
                    w_dsel = w_floor;
                end
            end
        end else if (r_left != '0) begin
            n_left = r_left - 1'b1;
            if (r_left == KICK_W'(1)) begin
                w_load = 1'b1;
            end
        end
        n_duty = w_load ? pct_to_duty(w_dsel) : r_duty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_applied <= '0;
            r_target  <= '0;
            r_left    <= '0;
            r_duty    <= '0;
        end else if (i_ctl.apply) begin
            r_speed   <= n_speed;
            r_applied <= n_applied;
            r_target  <= n_target;
            r_left    <= n_left;
            r_duty    <= n_duty;
        end
    end

    assign o_speed          = r_speed;
    assign o_next.duty      = n_duty;
    assign o_next.level_pct = n_speed;
    assign o_next.kicking   = (n_left != '0);

endmodule

`default_nettype wire

// File: hdl/fan_speed_controller_hysteresis_top.sv
// ----------------------------------------------------------------------------
// Fan speed controller with hysteresis and start kick
// Decides the fan percent from fin-temperature readings and runs the start
// kick on millisecond ticks, giving one result beat per input beat.
//
//   Channel   Direction  Handshake                 Beat
//   in        input      i_in_valid / o_in_ready   t_in_beat
//   out       output     o_out_valid / i_out_ready t_out_beat
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A tick, a fixed-mode reading or a reading off the ramp goes from S_CALC
// to S_APPLY; a reading on the ramp passes through S_DIV in between, where the
// bit-serial divider forms one quotient bit a cycle; S_APPLY waits for a free slot.
// One item is in work at a time; the next is taken once the last result has
// been placed in the output register, which may still be waiting.
// Reset is synchronous and takes effect at the first edge with i_rst_n low.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_speed_controller_hysteresis_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  fsc_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output fsc_pkg::t_out_beat            o_out_beat,
    input  wire                           i_cfg_we,
    input  wire  [fsc_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire  [fsc_pkg::CFG_W-1:0]     i_cfg_data
);
    import fsc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CALC  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    localparam logic signed [CW-1:0] ONE_C = CW'(1 << TEMP_FRAC_BITS);
    localparam logic signed [CW-1:0] T_MIN = CW'(-120 * (1 << TEMP_FRAC_BITS));
    localparam logic signed [CW-1:0] T_MAX = CW'(125 * (1 << TEMP_FRAC_BITS));

    logic [1:0]        r_state, n_state;
    t_in_beat          r_item;
    logic [PCT_W-1:0]  r_pct,   n_pct;
    logic [1:0]        r_mode;
    logic [THR_W-1:0]  r_low;
    logic [THR_W-1:0]  r_high;
    logic [THR_W-1:0]  r_min;
    logic [KICK_W-1:0] r_kick;
    logic              r_out_valid;
    t_out_beat         r_out_beat;

    logic signed [CW-1:0] w_t, w_lo, w_hi, w_den, w_diff;
    logic [PCT_W-1:0]     w_calc_pct;
    logic                 w_need_div;
    logic [QUO_W:0]       w_sum;
    logic                 w_slot_free;
    logic [PCT_W-1:0]     w_speed;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_drv_ctl  drv_ctl;
    t_drv_cfg  drv_cfg;
    t_out_beat drv_next;

    fsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fsc_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (drv_ctl),
        .i_pct   (r_pct),
        .i_cfg   (drv_cfg),
        .o_speed (w_speed),
        .o_next  (drv_next)
    );

    assign drv_cfg.min_duty   = r_min;
    assign drv_cfg.kick_ticks = r_kick;

    always_comb begin
        w_t        = CW'(r_item.fin_temp);
        w_lo       = CW'(r_low) << TEMP_FRAC_BITS;
        w_hi       = CW'(r_high) << TEMP_FRAC_BITS;
        w_den      = w_hi - w_lo;
        w_diff     = w_t - w_lo;
        w_need_div = 1'b0;
        unique case (r_mode)
            MODE_OFF:  w_calc_pct = PCT_OFF;
            MODE_HALF: w_calc_pct = PCT_HALF;
            MODE_FULL: w_calc_pct = PCT_FULL;
            MODE_AUTO: begin
                if (!r_item.temp_present || w_t < T_MIN || w_t > T_MAX) begin
                    w_calc_pct = PCT_OFF;
                end else if ((w_t <<< 1) < (w_lo <<< 1) - ONE_C) begin
                    w_calc_pct = PCT_OFF;
                end else if ((w_t <<< 1) > (w_hi <<< 1) + ONE_C) begin
                    w_calc_pct = PCT_FULL;
                end else if (w_t <= w_lo) begin
                    w_calc_pct = (w_speed == PCT_OFF) ? PCT_OFF : PCT_RAMP_BASE;
                end else if (w_den <= 0) begin
                    w_calc_pct = PCT_FULL;
                end else begin
                    w_calc_pct = PCT_OFF;
                    w_need_div = 1'b1;
                end
            end
            default: w_calc_pct = PCT_OFF;
        endcase
    end

    assign w_sum       = (QUO_W + 1)'(div_rsp.quo) + (QUO_W + 1)'(PCT_RAMP_BASE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state       = r_state;
        n_pct         = r_pct;
        div_req.start = 1'b0;
        div_req.num   = NUM_W'(w_diff <<< 6) + NUM_W'(w_diff <<< 4);
        div_req.den   = DEN_W'(w_den);
        drv_ctl.apply = 1'b0;
        drv_ctl.tick  = r_item.kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_pct = w_calc_pct;
                if (!r_item.kind && w_need_div) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_pct   = (w_sum > (QUO_W + 1)'(PCT_FULL)) ? PCT_FULL : w_sum[PCT_W-1:0];
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (w_slot_free) begin
                    drv_ctl.apply = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_AUTO;
            r_low       <= 6'd40;
            r_high      <= 6'd50;
            r_min       <= 6'd30;
            r_kick      <= 16'd500;
        end else begin
            r_state <= n_state;
            if (drv_ctl.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FAN_MODE: r_mode <= i_cfg_data[1:0];
                    REG_LOW_THR:  r_low  <= i_cfg_data[THR_W-1:0];
                    REG_HIGH_THR: r_high <= i_cfg_data[THR_W-1:0];
                    REG_MIN_DUTY: r_min  <= i_cfg_data[THR_W-1:0];
                    REG_KICK:     r_kick <= i_cfg_data[KICK_W-1:0];
                    default: ;
                endcase
            end
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_beat;
        end
        r_pct <= n_pct;
        if (drv_ctl.apply) begin
            r_out_beat <= drv_next;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_apply_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drv_ctl.apply |-> w_slot_free)
        else $error("result written over a beat still waiting");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_APPLY |-> r_pct <= PCT_FULL)
        else $error("decided percent above full speed");

    a_kick_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.kicking) |-> o_out_beat.duty == DUTY_FULL)
        else $error("start kick without full duty");

    a_apply_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drv_ctl.apply |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented after apply");

endmodule

`default_nettype wire
